@@ hdl/ssfl_pkg.sv @@
package ssfl_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTRY_W     = ADDR_W + HANDLE_BITS;

  // result field widths
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_HDL_W   = 16;
  localparam int unsigned ENTRIES_W   = 9;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       sym_handle;
  } ssfl_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_HDL_W-1:0] found_handle;
    logic [ADDR_W-1:0]    offset;
    logic [ENTRIES_W-1:0] entries;
  } ssfl_out_t;

endpackage

@@ hdl/sorted_symbol_floor_lookup.sv @@
// Sorted symbol table with floor lookup.
// Input channel: in_valid_i / in_stall_o carry one item (op, addr, sym_handle).
// An insert (op 0) places the entry after all stored entries whose address is
// not above its own; a full table drops it and reports status 1. A lookup
// (op 1) returns the entry with the highest address not above the target,
// the last inserted among equal addresses, and target minus that address;
// status 2 when nothing qualifies. Every result carries the entry count.
// Output channel: out_valid_o / out_stall_i carry one result per item.
// Sequence: the binary search probes the middle entry through the registered
// table read port. An insert then moves one entry per cycle from the end down
// to its position, drains the last read and places the new entry; a lookup
// makes one extra read of the floor entry. The result then waits until the
// output register is free. A full-table insert skips the search.
// One item is in work at a time; in_stall_o is high until its result moves
// into the output register, which holds it while the receiver stalls.
// Reset empties the table at once (count cleared) and drops any pending item.
module sorted_symbol_floor_lookup import ssfl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ssfl_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ssfl_out_t out_item_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_PROBE  = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_LDONE  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       total_q, total_d;
  logic [CNT_W-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CNT_W-1:0]       pos_q, pos_d, i_q, i_d;
  logic [IDX_W-1:0]       waddr_q, waddr_d;
  logic                   pend_q, pend_d;
  logic                   out_valid_q, out_valid_d;
  logic                   op_q, op_d;
  logic [ADDR_W-1:0]      key_q, key_d;
  logic [HANDLE_BITS-1:0] hdl_q, hdl_d;
  ssfl_out_t              res_q, res_d, out_q, out_d;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]      rd_addr;
  logic [HANDLE_BITS-1:0] rd_hdl;
  logic [CNT_W:0]         mid_sum;
  logic [CNT_W-1:0]       lo_m1, i_m1;
  logic                   accept, out_free;

  ssfl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_addr  = ram_rdata[ENTRY_W-1 -: ADDR_W];
  assign rd_hdl   = ram_rdata[HANDLE_BITS-1:0];
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign lo_m1    = lo_q - CNT_W'(1);
  assign i_m1     = i_q - CNT_W'(1);
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer: search, then shift and place (insert) or fetch (lookup), then result
  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    pos_d       = pos_q;
    i_d         = i_q;
    waddr_d     = waddr_q;
    pend_d      = pend_q;
    op_d        = op_q;
    key_d       = key_q;
    hdl_d       = hdl_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = waddr_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = mid_sum[IDX_W:1];

    // output register drains independently
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = in_item_i.op;
          key_d = in_item_i.addr;
          hdl_d = HANDLE_BITS'(in_item_i.sym_handle);
          lo_d  = '0;
          hi_d  = total_q;
          res_d = '0;
          if (in_item_i.op == OP_INSERT && total_q >= CNT_W'(TABLE_DEPTH)) begin
            res_d.status  = STATUS_FULL;
            res_d.entries = ENTRIES_W'(total_q);
            state_d       = S_RESULT;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (lo_q < hi_q) begin
          // probe the middle entry
          ram_re  = 1'b1;
          mid_d   = mid_sum[CNT_W:1];
          state_d = S_PROBE;
        end else if (op_q == OP_INSERT) begin
          pos_d   = lo_q;
          i_d     = total_q;
          pend_d  = 1'b0;
          state_d = S_SHIFT;
        end else if (lo_q == '0) begin
          res_d.status  = STATUS_MISS;
          res_d.entries = ENTRIES_W'(total_q);
          state_d       = S_RESULT;
        end else begin
          // fetch the floor entry
          ram_re    = 1'b1;
          ram_raddr = lo_m1[IDX_W-1:0];
          state_d   = S_LDONE;
        end
      end
      S_PROBE: begin
        if (key_q >= rd_addr) begin
          lo_d = mid_q + CNT_W'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = S_SEARCH;
      end
      S_SHIFT: begin
        // read entry i-1 while writing the one read last cycle to its slot
        ram_we    = pend_q;
        ram_waddr = waddr_q;
        ram_wdata = ram_rdata;
        if (i_q != pos_q) begin
          ram_re    = 1'b1;
          ram_raddr = i_m1[IDX_W-1:0];
          pend_d    = 1'b1;
          waddr_d   = i_q[IDX_W-1:0];
          i_d       = i_m1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            // place the new entry
            ram_we        = 1'b1;
            ram_waddr     = pos_q[IDX_W-1:0];
            ram_wdata     = {key_q, hdl_q};
            total_d       = total_q + CNT_W'(1);
            res_d.status  = STATUS_OK;
            res_d.entries = ENTRIES_W'(total_q + CNT_W'(1));
            state_d       = S_RESULT;
          end
        end
      end
      S_LDONE: begin
        res_d.status       = STATUS_OK;
        res_d.found_handle = OUT_HDL_W'(rd_hdl);
        res_d.offset       = key_q - rd_addr;
        res_d.entries      = ENTRIES_W'(total_q);
        state_d            = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers and payload
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    pos_q   <= pos_d;
    i_q     <= i_d;
    waddr_q <= waddr_d;
    op_q    <= op_d;
    key_q   <= key_d;
    hdl_q   <= hdl_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ hdl/ssfl_ram.sv @@
module ssfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ssfl_chk.sv @@
module ssfl_chk import ssfl_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input ssfl_in_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input ssfl_out_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // an accepted item keeps the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a second item at once");

  // only defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status == STATUS_OK ||
                     out_item_o.status == STATUS_FULL ||
                     out_item_o.status == STATUS_MISS))
    else $error("undefined status code");

  // a dropped insert only happens on a full table
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == STATUS_FULL |->
      out_item_o.entries == ENTRIES_W'(TABLE_DEPTH))
    else $error("full status with spare room");

  // a miss or a drop carries no handle and no offset
  a_empty_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != STATUS_OK |->
      out_item_o.found_handle == '0 && out_item_o.offset == '0)
    else $error("miss carries payload");

endmodule

bind sorted_symbol_floor_lookup ssfl_chk u_ssfl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
